// File: src/pld_pkg.sv
// Package for the positional list block: state encoding, request and status codes.
// No dependencies; used by positional_list_insert_delete_top.
package pld_pkg;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISP,
    S_INS_CHK,
    S_INS_WR,
    S_DEL_CAP,
    S_DEL_CHK,
    S_DEL_WR,
    S_RO_RD,
    S_RO_EMIT,
    S_EMIT
  } state_t;

  typedef logic [1:0] mode_t;
  typedef logic [1:0] status_t;

  localparam mode_t MODE_APPEND = 2'd0;
  localparam mode_t MODE_INSERT = 2'd1;
  localparam mode_t MODE_DELETE = 2'd2;
  localparam mode_t MODE_READ   = 2'd3;

  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_RANGE = 2'd1;
  localparam status_t ST_EMPTY = 2'd2;
  localparam status_t ST_FULL  = 2'd3;

endpackage

// File: src/positional_list_insert_delete_top.sv
// Positional list top level: cell memory, length register and shift sequencer.
// Depends on pld_pkg.
//
// Usage:
//   Input channel (in_*): one request per transfer. in_tuser carries the mode
//   (append, insert, delete, read out), in_tdata the value and 1-based position.
//   Result channel (out_*): one status transfer per append, insert or delete;
//   a read out gives one transfer per element, tlast on the final one, or a
//   single empty status for an empty list. Delete returns the removed value.
//   in_tready is high only while the sequencer is idle. Insert and delete
//   shift the cells above the position one at a time; each shift step is
//   one read and one write on the cell memory.
//   Results sit in an output register; a stalled receiver holds the sequencer
//   in its emit state, and a new request is still taken while the last result
//   of the previous one waits.
//   Reset (rst_n low, synchronous) empties the list and drops out_tvalid.
//   Cell contents are not cleared; only cells below the length are read.
module positional_list_insert_delete_top #(
  parameter int DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [31:0] value, [37:32] position, [39:38] zero
  input  logic [1:0]  in_tuser,   // [1:0] mode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] element
  output logic [2:0]  out_tuser,  // [1:0] status, [2] element_valid
  output logic        out_tlast
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LW = $clog2(DEPTH + 1);
  localparam int CW = (LW + 1 > 7) ? LW + 1 : 7;

  pld_pkg::state_t state_r, state_nxt;

  logic [LW-1:0] length_r, length_nxt;
  logic [AW-1:0] i_r, i_nxt;
  pld_pkg::mode_t mode_r;
  logic [31:0] value_r;
  logic [5:0]  pos_r;

  pld_pkg::status_t res_status_r, res_status_nxt;
  logic [31:0]      res_elem_r, res_elem_nxt;
  logic             res_ev_r, res_ev_nxt;

  logic             out_tvalid_r, out_tvalid_nxt;
  pld_pkg::status_t out_status_r, out_status_nxt;
  logic [31:0]      out_elem_r, out_elem_nxt;
  logic             out_ev_r, out_ev_nxt;
  logic             out_last_r, out_last_nxt;

  logic [31:0] mem [DEPTH];
  logic [31:0] rd_data_r;
  logic          wr_en, rd_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [31:0]   wr_data;

  logic          in_xfer, out_free, out_load, is_full, ro_last;
  logic [AW-1:0] pos_m1;
  logic [CW-1:0] pos_ext, len_ext;

  assign in_tready = (state_r == pld_pkg::S_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign out_free  = !out_tvalid_r || out_tready;
  assign is_full   = (length_r == LW'(DEPTH));
  assign pos_m1    = AW'(pos_r - 6'd1);
  assign pos_ext   = CW'(pos_r);
  assign len_ext   = CW'(length_r);
  assign ro_last   = ((LW'(i_r) + LW'(1)) == length_r);

  always_comb begin
    state_nxt      = state_r;
    length_nxt     = length_r;
    i_nxt          = i_r;
    res_status_nxt = res_status_r;
    res_elem_nxt   = res_elem_r;
    res_ev_nxt     = res_ev_r;
    out_load       = 1'b0;
    out_status_nxt = out_status_r;
    out_elem_nxt   = out_elem_r;
    out_ev_nxt     = out_ev_r;
    out_last_nxt   = out_last_r;
    wr_en          = 1'b0;
    wr_addr        = i_r;
    wr_data        = rd_data_r;
    rd_en          = 1'b0;
    rd_addr        = i_r;

    unique case (state_r)
      pld_pkg::S_IDLE: begin
        if (in_xfer) state_nxt = pld_pkg::S_DISP;
      end
      pld_pkg::S_DISP: begin
        res_status_nxt = pld_pkg::ST_OK;
        res_elem_nxt   = 32'd0;
        res_ev_nxt     = 1'b0;
        state_nxt      = pld_pkg::S_EMIT;
        unique case (mode_r)
          pld_pkg::MODE_APPEND: begin
            if (is_full) begin
              res_status_nxt = pld_pkg::ST_FULL;
            end else begin
              wr_en      = 1'b1;
              wr_addr    = AW'(length_r);
              wr_data    = value_r;
              length_nxt = length_r + LW'(1);
            end
          end
          pld_pkg::MODE_INSERT: begin
            if (pos_r == 6'd0 || pos_ext > len_ext + CW'(1)) begin
              res_status_nxt = pld_pkg::ST_RANGE;
            end else if (is_full) begin
              res_status_nxt = pld_pkg::ST_FULL;
            end else begin
              i_nxt     = AW'(length_r);
              state_nxt = pld_pkg::S_INS_CHK;
            end
          end
          pld_pkg::MODE_DELETE: begin
            if (length_r == LW'(0)) begin
              res_status_nxt = pld_pkg::ST_EMPTY;
            end else if (pos_r == 6'd0 || pos_ext > len_ext) begin
              res_status_nxt = pld_pkg::ST_RANGE;
            end else begin
              rd_en     = 1'b1;
              rd_addr   = pos_m1;
              i_nxt     = pos_m1;
              state_nxt = pld_pkg::S_DEL_CAP;
            end
          end
          pld_pkg::MODE_READ: begin
            if (length_r == LW'(0)) begin
              res_status_nxt = pld_pkg::ST_EMPTY;
            end else begin
              i_nxt     = '0;
              state_nxt = pld_pkg::S_RO_RD;
            end
          end
          default: state_nxt = pld_pkg::S_EMIT;
        endcase
      end
      pld_pkg::S_INS_CHK: begin
        if (i_r == pos_m1) begin
          wr_en      = 1'b1;
          wr_data    = value_r;
          length_nxt = length_r + LW'(1);
          state_nxt  = pld_pkg::S_EMIT;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = i_r - AW'(1);
          state_nxt = pld_pkg::S_INS_WR;
        end
      end
      pld_pkg::S_INS_WR: begin
        wr_en     = 1'b1;
        i_nxt     = i_r - AW'(1);
        state_nxt = pld_pkg::S_INS_CHK;
      end
      pld_pkg::S_DEL_CAP: begin
        res_elem_nxt = rd_data_r;
        res_ev_nxt   = 1'b1;
        state_nxt    = pld_pkg::S_DEL_CHK;
      end
      pld_pkg::S_DEL_CHK: begin
        if (ro_last) begin
          length_nxt = length_r - LW'(1);
          state_nxt  = pld_pkg::S_EMIT;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = i_r + AW'(1);
          state_nxt = pld_pkg::S_DEL_WR;
        end
      end
      pld_pkg::S_DEL_WR: begin
        wr_en     = 1'b1;
        i_nxt     = i_r + AW'(1);
        state_nxt = pld_pkg::S_DEL_CHK;
      end
      pld_pkg::S_RO_RD: begin
        rd_en     = 1'b1;
        state_nxt = pld_pkg::S_RO_EMIT;
      end
      pld_pkg::S_RO_EMIT: begin
        if (out_free) begin
          out_load       = 1'b1;
          out_status_nxt = pld_pkg::ST_OK;
          out_elem_nxt   = rd_data_r;
          out_ev_nxt     = 1'b1;
          out_last_nxt   = ro_last;
          if (ro_last) begin
            state_nxt = pld_pkg::S_IDLE;
          end else begin
            i_nxt     = i_r + AW'(1);
            state_nxt = pld_pkg::S_RO_RD;
          end
        end
      end
      pld_pkg::S_EMIT: begin
        if (out_free) begin
          out_load       = 1'b1;
          out_status_nxt = res_status_r;
          out_elem_nxt   = res_elem_r;
          out_ev_nxt     = res_ev_r;
          out_last_nxt   = 1'b1;
          state_nxt      = pld_pkg::S_IDLE;
        end
      end
      default: state_nxt = pld_pkg::S_IDLE;
    endcase

    if (out_load) out_tvalid_nxt = 1'b1;
    else if (out_tready) out_tvalid_nxt = 1'b0;
    else out_tvalid_nxt = out_tvalid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= pld_pkg::S_IDLE;
      length_r     <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      length_r     <= length_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r          <= i_nxt;
    res_status_r <= res_status_nxt;
    res_elem_r   <= res_elem_nxt;
    res_ev_r     <= res_ev_nxt;
    out_status_r <= out_status_nxt;
    out_elem_r   <= out_elem_nxt;
    out_ev_r     <= out_ev_nxt;
    out_last_r   <= out_last_nxt;
    if (in_xfer) begin
      mode_r  <= in_tuser;
      value_r <= in_tdata[31:0];
      pos_r   <= in_tdata[37:32];
    end
  end

  // cell memory: one write, one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data_r <= mem[rd_addr];
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_elem_r;
  assign out_tuser  = {out_ev_r, out_status_r};
  assign out_tlast  = out_last_r;

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    length_r <= LW'(DEPTH))
    else $error("list length exceeds depth");

  a_accept_disp: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> state_r == pld_pkg::S_DISP)
    else $error("accepted request not dispatched");

  a_nonlast_readout: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && !out_last_nxt) |-> state_r == pld_pkg::S_RO_EMIT)
    else $error("non-final result outside read out");

  a_len_step: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (length_r == $past(length_r)) ||
                     (length_r == $past(length_r) + LW'(1)) ||
                     (length_r == $past(length_r) - LW'(1)))
    else $error("length moved by more than one");

endmodule
